FILE: hw/rtl/ffsa_pkg.sv
// ----------------------------------------------------------------------------
// ffsa_pkg
// Types and constants shared by the first-free slot allocator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ffsa_pkg;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam int WORD_W    = 32;
  localparam int BIT_W     = 5;
  localparam int INDEX_W   = 6;
  localparam int COUNT_W   = 7;
  localparam int TOTAL_W   = 32;
  localparam int Q16_W     = 17;
  localparam int Q16_ONE   = 65536;

  typedef struct packed {
    logic               command;
    logic [INDEX_W-1:0] free_index;
  } req_t;

  typedef struct packed {
    logic               granted;
    logic [INDEX_W-1:0] slot_index;
    logic [COUNT_W-1:0] busy_count;
    logic [TOTAL_W-1:0] alloc_total;
    logic [TOTAL_W-1:0] free_total;
    logic [Q16_W-1:0]   occupancy_q16;
  } rsp_t;

  typedef enum logic {
    ST_IDLE,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic commit;
  } ctrl_cmd_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ffsa_ctrl.sv
// ----------------------------------------------------------------------------
// ffsa_ctrl
// Request sequencer: takes a request, lets the datapath commit it once the
// result register is free, and tracks the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module ffsa_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  req_valid,
  output logic                 req_ready,
  output logic                 rsp_valid,
  input  wire                  rsp_ready,
  output ffsa_pkg::ctrl_cmd_t  cmd
);

  ffsa_pkg::state_t state;
  ffsa_pkg::state_t state_next;
  logic             rsp_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ffsa_pkg::ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    req_ready      = 1'b0;
    cmd.load       = 1'b0;
    cmd.commit     = 1'b0;
    rsp_valid_next = rsp_valid && !rsp_ready;
    case (state)
      ffsa_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = ffsa_pkg::ST_COMMIT;
        end
      end
      ffsa_pkg::ST_COMMIT: begin
        // result register must be empty or draining
        if (!rsp_valid || rsp_ready) begin
          cmd.commit     = 1'b1;
          rsp_valid_next = 1'b1;
          state_next     = ffsa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ffsa_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ffsa_dpath.sv
// ----------------------------------------------------------------------------
// ffsa_dpath
// Busy bitmap, word-level free search, in-word pick, counters, incremental
// Q16 occupancy and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ffsa_dpath #(
  parameter int SLOTS = 64
) (
  input  wire                 clk,
  input  wire                 rst,
  input  ffsa_pkg::ctrl_cmd_t cmd,
  input  ffsa_pkg::req_t      req,
  output ffsa_pkg::rsp_t      rsp
);

  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int NWORDS = (SLOTS + ffsa_pkg::WORD_W - 1) / ffsa_pkg::WORD_W;
  localparam int WSEL_W = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int PAD    = NWORDS * ffsa_pkg::WORD_W;
  localparam int POS_W  = WSEL_W + ffsa_pkg::BIT_W;
  localparam int STEP_Q = ffsa_pkg::Q16_ONE / SLOTS;
  localparam int STEP_R = ffsa_pkg::Q16_ONE % SLOTS;

  localparam logic [IDX_W:0]             SLOTS_C  = (IDX_W + 1)'(SLOTS);
  localparam logic [IDX_W:0]             STEP_R_C = (IDX_W + 1)'(STEP_R);
  localparam logic [ffsa_pkg::Q16_W-1:0] STEP_Q_C = ffsa_pkg::Q16_W'(STEP_Q);

  // state
  logic [SLOTS-1:0]             busy_map;
  logic [CNT_W-1:0]             busy_slots;
  logic [ffsa_pkg::TOTAL_W-1:0] allocs_served;
  logic [ffsa_pkg::TOTAL_W-1:0] frees_served;
  logic [ffsa_pkg::Q16_W-1:0]   occupancy;
  logic [IDX_W-1:0]             occ_rem;

  // request held between accept and commit
  logic                         cmd_r;
  logic [ffsa_pkg::INDEX_W-1:0] idx_r;
  logic [WSEL_W-1:0]            word_sel;
  logic                         word_found;

  logic [PAD-1:0]               map_pad;
  logic [NWORDS-1:0]            word_full;
  logic [WSEL_W-1:0]            word_pick;
  logic                         word_any;
  logic [ffsa_pkg::WORD_W-1:0]  cur_word;
  logic [ffsa_pkg::BIT_W-1:0]   bit_pick;
  logic [POS_W-1:0]             alloc_pos;
  logic [IDX_W-1:0]             free_pos;
  logic                         free_ok;
  logic                         do_alloc;
  logic                         do_free;

  logic [SLOTS-1:0]             busy_map_next;
  logic [CNT_W-1:0]             busy_slots_next;
  logic [ffsa_pkg::Q16_W-1:0]   occupancy_next;
  logic [IDX_W-1:0]             occ_rem_next;
  logic [IDX_W:0]               rem_up;
  logic [IDX_W:0]               rem_dn;

  // padding bits past the pool read as busy
  always_comb begin
    map_pad             = '1;
    map_pad[SLOTS-1:0]  = busy_map;
  end

  // word-level search, lowest word with a free bit
  always_comb begin
    word_pick = '0;
    word_any  = 1'b0;
    for (int w = NWORDS - 1; w >= 0; w--) begin
      word_full[w] = &map_pad[w*ffsa_pkg::WORD_W +: ffsa_pkg::WORD_W];
      if (!word_full[w]) begin
        word_pick = WSEL_W'(w);
        word_any  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r      <= req.command;
      idx_r      <= req.free_index;
      word_sel   <= word_pick;
      word_found <= word_any;
    end
  end

  // in-word pick, lowest free bit of the selected word
  always_comb begin
    cur_word = map_pad[int'(word_sel)*ffsa_pkg::WORD_W +: ffsa_pkg::WORD_W];
    bit_pick = '0;
    for (int b = ffsa_pkg::WORD_W - 1; b >= 0; b--) begin
      if (!cur_word[b]) begin
        bit_pick = ffsa_pkg::BIT_W'(b);
      end
    end
  end

  assign alloc_pos = {word_sel, bit_pick};
  assign free_pos  = IDX_W'(idx_r);
  assign free_ok   = (int'(idx_r) < SLOTS) && busy_map[free_pos];
  assign do_alloc  = (cmd_r == ffsa_pkg::CMD_ALLOC) && word_found;
  assign do_free   = (cmd_r == ffsa_pkg::CMD_FREE) && free_ok;

  // occupancy tracked as quotient and remainder of busy*65536/SLOTS
  assign rem_up = {1'b0, occ_rem} + STEP_R_C;
  assign rem_dn = {1'b0, occ_rem} + SLOTS_C - STEP_R_C;

  always_comb begin
    busy_map_next   = busy_map;
    busy_slots_next = busy_slots;
    occupancy_next  = occupancy;
    occ_rem_next    = occ_rem;
    if (do_alloc) begin
      busy_map_next[alloc_pos[IDX_W-1:0]] = 1'b1;
      busy_slots_next = busy_slots + CNT_W'(1);
      if (rem_up >= SLOTS_C) begin
        occ_rem_next   = IDX_W'(rem_up - SLOTS_C);
        occupancy_next = occupancy + STEP_Q_C + ffsa_pkg::Q16_W'(1);
      end else begin
        occ_rem_next   = IDX_W'(rem_up);
        occupancy_next = occupancy + STEP_Q_C;
      end
    end else if (do_free) begin
      busy_map_next[free_pos] = 1'b0;
      busy_slots_next = busy_slots - CNT_W'(1);
      if ({1'b0, occ_rem} >= STEP_R_C) begin
        occ_rem_next   = IDX_W'({1'b0, occ_rem} - STEP_R_C);
        occupancy_next = occupancy - STEP_Q_C;
      end else begin
        occ_rem_next   = IDX_W'(rem_dn);
        occupancy_next = occupancy - STEP_Q_C - ffsa_pkg::Q16_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_map      <= '0;
      busy_slots    <= '0;
      allocs_served <= '0;
      frees_served  <= '0;
      occupancy     <= '0;
      occ_rem       <= '0;
    end else if (cmd.commit) begin
      busy_map   <= busy_map_next;
      busy_slots <= busy_slots_next;
      occupancy  <= occupancy_next;
      occ_rem    <= occ_rem_next;
      if (do_alloc) begin
        allocs_served <= allocs_served + ffsa_pkg::TOTAL_W'(1);
      end
      if (do_free) begin
        frees_served <= frees_served + ffsa_pkg::TOTAL_W'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp.granted       <= do_alloc || do_free;
      rsp.slot_index    <= do_alloc ? ffsa_pkg::INDEX_W'(alloc_pos) : '0;
      rsp.busy_count    <= ffsa_pkg::COUNT_W'(busy_slots_next);
      rsp.alloc_total   <= do_alloc ? allocs_served + ffsa_pkg::TOTAL_W'(1)
                                    : allocs_served;
      rsp.free_total    <= do_free ? frees_served + ffsa_pkg::TOTAL_W'(1)
                                   : frees_served;
      rsp.occupancy_q16 <= occupancy_next;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/first_free_slot_allocator.sv
// ----------------------------------------------------------------------------
// first_free_slot_allocator
// Allocates the lowest free slot of a fixed pool or releases a given slot,
// reporting busy count, transfer totals and Q16 occupancy with each result.
// ----------------------------------------------------------------------------
// A request is accepted in the idle state, where the busy map is scanned for
// the lowest 32-slot word that has a free slot; in the commit state the
// lowest free bit of that word is picked and the map, counters and occupancy
// are updated while the result register is loaded. The commit waits while an
// earlier result is still untaken, and no new request is accepted until the
// last one has committed. Occupancy is kept as a running quotient and
// remainder, so no divider is needed. The busy map lives in flip-flops
// cleared by reset; no clearing pass is run.
`default_nettype none

module first_free_slot_allocator #(
  parameter int SLOTS = 64
) (
  input  wire             clk,
  input  wire             rst,
  input  wire             req_valid,
  output logic            req_ready,
  input  ffsa_pkg::req_t  req,
  output logic            rsp_valid,
  input  wire             rsp_ready,
  output ffsa_pkg::rsp_t  rsp
);

  ffsa_pkg::ctrl_cmd_t cmd;

  ffsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cmd       (cmd)
  );

  ffsa_dpath #(
    .SLOTS (SLOTS)
  ) u_dpath (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .req (req),
    .rsp (rsp)
  );

endmodule

`default_nettype wire

FILE: test/tb_first_free_slot_allocator.sv
// ----------------------------------------------------------------------------
// tb_first_free_slot_allocator
// Self-checking testbench for the first-free slot allocator. Requests go in
// over a valid/ready channel with random gaps. A model of the busy map and
// the counters predicts each result, and every result transfer is checked
// field by field. The run covers a directed pass, a full-pool fill and
// release, random alloc/free phases and a long output stall.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_first_free_slot_allocator;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int POOL_SLOTS  = 64;
  localparam int IDLE_LIMIT  = 5000;
  localparam int STALL_LONG  = 150;
  localparam int TAIL_CYCLES = 20;

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_ready;
  ffsa_pkg::req_t req;
  logic rsp_valid;
  logic rsp_ready;
  ffsa_pkg::rsp_t rsp;

  // slot pool mirror
  logic [POOL_SLOTS-1:0]        slot_busy;
  int                           busy_total;
  logic [ffsa_pkg::TOTAL_W-1:0] allocs_done;
  logic [ffsa_pkg::TOTAL_W-1:0] frees_done;
  int                           occ_q16;

  ffsa_pkg::rsp_t slot_results_q[$];

  int errors;
  int requests_sent;
  int results_seen;
  int idle_cycles;
  int hold_cycles;
  bit quiet;
  int n_alloc_ok;
  int n_alloc_full;
  int n_free_ok;
  int n_free_idle;

  first_free_slot_allocator #(
    .SLOTS(POOL_SLOTS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_failure(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // applies one request to the pool mirror and returns the result it gives
  function automatic ffsa_pkg::rsp_t serve_request(input ffsa_pkg::req_t r);
    ffsa_pkg::rsp_t res;
    int             pick;
    res  = '0;
    pick = -1;
    if (r.command == ffsa_pkg::CMD_ALLOC) begin
      for (int i = POOL_SLOTS - 1; i >= 0; i--)
        if (!slot_busy[i]) pick = i;
      if (pick >= 0) begin
        slot_busy[pick] = 1'b1;
        busy_total++;
        allocs_done++;
        occ_q16 = int'((longint'(busy_total) * ffsa_pkg::Q16_ONE) / POOL_SLOTS);
        res.granted    = 1'b1;
        res.slot_index = ffsa_pkg::INDEX_W'(pick);
        n_alloc_ok++;
      end else begin
        n_alloc_full++;
      end
    end else begin
      if (int'(r.free_index) < POOL_SLOTS && slot_busy[r.free_index]) begin
        slot_busy[r.free_index] = 1'b0;
        if (busy_total > 0) busy_total--;
        frees_done++;
        occ_q16 = int'((longint'(busy_total) * ffsa_pkg::Q16_ONE) / POOL_SLOTS);
        res.granted = 1'b1;
        n_free_ok++;
      end else begin
        n_free_idle++;
      end
    end
    res.busy_count    = ffsa_pkg::COUNT_W'(busy_total);
    res.alloc_total   = allocs_done;
    res.free_total    = frees_done;
    res.occupancy_q16 = ffsa_pkg::Q16_W'(occ_q16);
    return res;
  endfunction

  // first busy slot at or after a random starting point, wrapping
  function automatic logic [ffsa_pkg::INDEX_W-1:0] pick_busy_slot();
    int start;
    int pick;
    start = $urandom_range(0, POOL_SLOTS - 1);
    pick  = start;
    for (int k = POOL_SLOTS - 1; k >= 0; k--)
      if (slot_busy[(start + k) % POOL_SLOTS]) pick = (start + k) % POOL_SLOTS;
    return ffsa_pkg::INDEX_W'(pick);
  endfunction

  task automatic send_request(input logic cmd,
                              input logic [ffsa_pkg::INDEX_W-1:0] idx);
    ffsa_pkg::req_t item;
    int             gap;
    item.command    = cmd;
    item.free_index = idx;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (!req_ready);
    slot_results_q.push_back(serve_request(item));
    requests_sent++;
  endtask

  task automatic send_random_request(input int alloc_pct);
    logic                         cmd;
    logic [ffsa_pkg::INDEX_W-1:0] idx;
    cmd = ($urandom_range(0, 99) < alloc_pct) ? ffsa_pkg::CMD_ALLOC : ffsa_pkg::CMD_FREE;
    idx = ffsa_pkg::INDEX_W'($urandom);
    if (cmd == ffsa_pkg::CMD_FREE && busy_total > 0 && $urandom_range(0, 9) < 8)
      idx = pick_busy_slot();
    send_request(cmd, idx);
  endtask

  task automatic test_directed_basics();
    send_request(ffsa_pkg::CMD_FREE, '0);
    send_request(ffsa_pkg::CMD_FREE, '1);
    repeat (4) send_request(ffsa_pkg::CMD_ALLOC, '0);
    send_request(ffsa_pkg::CMD_FREE, ffsa_pkg::INDEX_W'(1));
    send_request(ffsa_pkg::CMD_FREE, ffsa_pkg::INDEX_W'(1));
    send_request(ffsa_pkg::CMD_ALLOC, '1);
    send_request(ffsa_pkg::CMD_FREE, '0);
    send_request(ffsa_pkg::CMD_FREE, ffsa_pkg::INDEX_W'(3));
    send_request(ffsa_pkg::CMD_ALLOC, '1);
    send_request(ffsa_pkg::CMD_ALLOC, '0);
    send_request(ffsa_pkg::CMD_ALLOC, ffsa_pkg::INDEX_W'(6'h2a));
    send_request(ffsa_pkg::CMD_FREE, '1);
    send_request(ffsa_pkg::CMD_FREE, ffsa_pkg::INDEX_W'(2));
    send_request(ffsa_pkg::CMD_FREE, ffsa_pkg::INDEX_W'(6'h15));
    send_request(ffsa_pkg::CMD_ALLOC, ffsa_pkg::INDEX_W'(6'h15));
  endtask

  task automatic test_pool_full();
    while (busy_total < POOL_SLOTS)
      send_request(ffsa_pkg::CMD_ALLOC, ffsa_pkg::INDEX_W'($urandom));
    repeat (4) send_request(ffsa_pkg::CMD_ALLOC, ffsa_pkg::INDEX_W'($urandom));
    send_request(ffsa_pkg::CMD_FREE, ffsa_pkg::INDEX_W'(POOL_SLOTS - 1));
    send_request(ffsa_pkg::CMD_ALLOC, '0);
    send_request(ffsa_pkg::CMD_FREE, '0);
    send_request(ffsa_pkg::CMD_ALLOC, '1);
    send_request(ffsa_pkg::CMD_ALLOC, '1);
    while (busy_total > 0) send_request(ffsa_pkg::CMD_FREE, pick_busy_slot());
    send_request(ffsa_pkg::CMD_FREE, ffsa_pkg::INDEX_W'(POOL_SLOTS - 1));
  endtask

  task automatic test_random_mix();
    int pct;
    for (int p = 0; p < 6; p++) begin
      pct = (p % 3 == 0) ? 85 : (p % 3 == 1) ? 20 : 50;
      repeat (16) send_random_request(pct);
    end
  endtask

  task automatic test_back_to_back();
    quiet = 1'b1;
    repeat (30) send_random_request(55);
    quiet = 1'b0;
  endtask

  task automatic test_backpressure();
    quiet       = 1'b1;
    hold_cycles = STALL_LONG;
    repeat (30) send_random_request(60);
    quiet = 1'b0;
  endtask

  // result side
  initial begin : rsp_side
    int stall;
    forever begin
      if (hold_cycles > 0) begin
        stall       = hold_cycles;
        hold_cycles = 0;
      end else begin
        stall = quiet ? 0 : pick_gap();
      end
      if (stall > 0) begin
        rsp_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_rsp
    ffsa_pkg::rsp_t want;
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        idle_cycles = 0;
        results_seen++;
        if (slot_results_q.size() == 0) begin
          report_failure($sformatf("result %0d with nothing pending", results_seen));
        end else begin
          want = slot_results_q.pop_front();
          if (rsp.granted !== want.granted)
            report_failure($sformatf("result %0d granted %b want %b",
                                     results_seen, rsp.granted, want.granted));
          if (rsp.slot_index !== want.slot_index)
            report_failure($sformatf("result %0d slot_index %0d want %0d",
                                     results_seen, rsp.slot_index, want.slot_index));
          if (rsp.busy_count !== want.busy_count)
            report_failure($sformatf("result %0d busy_count %0d want %0d",
                                     results_seen, rsp.busy_count, want.busy_count));
          if (rsp.alloc_total !== want.alloc_total)
            report_failure($sformatf("result %0d alloc_total %0d want %0d",
                                     results_seen, rsp.alloc_total, want.alloc_total));
          if (rsp.free_total !== want.free_total)
            report_failure($sformatf("result %0d free_total %0d want %0d",
                                     results_seen, rsp.free_total, want.free_total));
          if (rsp.occupancy_q16 !== want.occupancy_q16)
            report_failure($sformatf("result %0d occupancy_q16 %0d want %0d",
                                     results_seen, rsp.occupancy_q16, want.occupancy_q16));
        end
      end else if (req_valid && req_ready) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
          $display("Test completed with failures");
          $finish;
        end
      end
    end
  end

  initial begin
    rst          <= 1'b1;
    req_valid    <= 1'b0;
    req          <= '0;
    slot_busy     = '0;
    busy_total    = 0;
    allocs_done   = '0;
    frees_done    = '0;
    occ_q16       = 0;
    errors        = 0;
    requests_sent = 0;
    results_seen  = 0;
    idle_cycles   = 0;
    hold_cycles   = 0;
    quiet         = 1'b0;
    n_alloc_ok    = 0;
    n_alloc_full  = 0;
    n_free_ok     = 0;
    n_free_idle   = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_directed_basics();
    test_pool_full();
    test_random_mix();
    test_back_to_back();
    test_backpressure();
    test_random_mix();

    req_valid <= 1'b0;
    while (slot_results_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d requests, %0d results checked, %0d errors",
             requests_sent, results_seen, errors);
    $display("allocs %0d granted, %0d refused on full pool;",
             n_alloc_ok, n_alloc_full);
    $display("frees %0d released, %0d on idle or out-of-range slots",
             n_free_ok, n_free_idle);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
